[rtl/core/mfde_pkg.sv]
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome frame store draw engine:
// command and response beats, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package mfde_pkg;

	// Frame store geometry.
	localparam int STORE_BYTES = 1024;
	localparam int STORE_AW    = $clog2(STORE_BYTES);
	localparam int BYTE_W      = 8;
	localparam int COL_W       = 7;   // 128 columns
	localparam int ROW_W       = 6;   // 64 rows
	localparam int BCOL_W      = 4;   // 16 byte columns per half row
	localparam int BIT_W       = 3;   // bit within a byte

	// Operation codes.
	typedef enum logic [1:0] {
		FN_PIXEL  = 2'd0,
		FN_FILL   = 2'd1,
		FN_INVERT = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	// Status codes.
	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_X1_OUT = 3'd1,
		STAT_Y1_OUT = 3'd2,
		STAT_X2_OUT = 3'd3,
		STAT_Y2_OUT = 3'd4
	} status_t;

	// Command beat.
	typedef struct packed {
		func_t                func;
		logic [7:0]           x1;
		logic [7:0]           y1;
		logic [7:0]           x2;
		logic [7:0]           y2;
		logic                 color;
		logic [STORE_AW-1:0]  addr;
	} cmd_t;

	// Response beat.
	typedef struct packed {
		status_t              status;
		logic [BYTE_W-1:0]    read_data;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DRAW,
		S_DRAIN,
		S_READ,
		S_RDWAIT,
		S_DONE
	} state_t;

endpackage

[rtl/core/mono_framebuffer_draw_engine.sv]
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// 128x64 monochrome frame store in split-half layout with pixel, rectangle
// fill, rectangle invert and byte read operations.
// ----------------------------------------------------------------------------
// Commands arrive on cmd (cmd_valid, cmd_stall) and each command beat yields
// one response beat on rsp (rsp_valid, rsp_stall): a status and, for a read,
// the stored byte. After reset the store is cleared by a pass over all 1024
// bytes, one byte per cycle, while cmd_stall stays high. One command is in
// work at a time: cmd_stall is high from acceptance until the response is
// loaded into the output register, and the next command can be taken in the
// following cycle. A rectangle touches N bytes (byte columns times rows) and
// the read-modify-write loop handles one byte per cycle, then S_DRAIN and
// S_DONE follow before rsp_valid rises; a pixel write takes the same path,
// a rejected pixel goes to S_DONE, a read through S_READ, S_RDWAIT, S_DONE.
// When the receiver stalls, the response is held in the output register; a
// further command can be taken and worked, but its response waits until
// the held beat has been taken.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  mfde_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mfde_pkg::rsp_t  rsp
);

	localparam int AW = mfde_pkg::STORE_AW;
	localparam int DW = mfde_pkg::BYTE_W;
	localparam int CW = mfde_pkg::COL_W;
	localparam int RW = mfde_pkg::ROW_W;
	localparam int BW = mfde_pkg::BCOL_W;
	localparam int XW = mfde_pkg::BIT_W;

	mfde_pkg::state_t state_q, state_d;

	// Operation registers.
	logic [RW-1:0]     yb_q, cur_y_q;
	logic [BW-1:0]     ca_q, cb_q, cur_c_q;
	logic [XW-1:0]     lo_q, hi_q;
	logic              inv_q, color_q;
	logic [AW-1:0]     addr_q;
	mfde_pkg::status_t status_q;
	logic [DW-1:0]     data_q;
	logic [AW-1:0]     clr_cnt_q;

	// Modify stage.
	logic              vld_s1;
	logic [AW-1:0]     addr_s1;
	logic [DW-1:0]     mask_s1;

	// Output register.
	logic              rsp_valid_q;
	mfde_pkg::rsp_t    rsp_q;

	// RAM connections.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DW-1:0]     ram_wdata, ram_rdata;

	logic              cmd_acc, rsp_free, last_byte, pix_reject;
	logic [CW-1:0]     x1c, x2c, xa, xb;
	logic [RW-1:0]     y1c, y2c, ya, yb;
	logic              x1_out, y1_out, x2_out, y2_out;
	mfde_pkg::status_t acc_status;
	logic [XW-1:0]     lo_cur, hi_cur;
	logic [DW-1:0]     mask_cur;
	logic [RW-1:0]     row_flip;
	logic [AW-1:0]     draw_addr;

	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Range checks, clamping and corner sorting of the incoming command.
	always_comb begin
		x1_out = cmd.x1[7];
		y1_out = |cmd.y1[7:6];
		x2_out = cmd.x2[7];
		y2_out = |cmd.y2[7:6];
		x1c    = x1_out ? '1 : cmd.x1[CW-1:0];
		y1c    = y1_out ? '1 : cmd.y1[RW-1:0];
		x2c    = x2_out ? '1 : cmd.x2[CW-1:0];
		y2c    = y2_out ? '1 : cmd.y2[RW-1:0];
		pix_reject = 1'b0;
		acc_status = mfde_pkg::STAT_OK;
		if (cmd.func == mfde_pkg::FN_PIXEL) begin
			xa = x1c;
			xb = x1c;
			ya = y1c;
			yb = y1c;
			if (x1_out) begin
				acc_status = mfde_pkg::STAT_X1_OUT;
				pix_reject = 1'b1;
			end else if (y1_out) begin
				acc_status = mfde_pkg::STAT_Y1_OUT;
				pix_reject = 1'b1;
			end
		end else begin
			xa = (x1c > x2c) ? x2c : x1c;
			xb = (x1c > x2c) ? x1c : x2c;
			ya = (y1c > y2c) ? y2c : y1c;
			yb = (y1c > y2c) ? y1c : y2c;
			if (x1_out) begin
				acc_status = mfde_pkg::STAT_X1_OUT;
			end else if (y1_out) begin
				acc_status = mfde_pkg::STAT_Y1_OUT;
			end else if (x2_out) begin
				acc_status = mfde_pkg::STAT_X2_OUT;
			end else if (y2_out) begin
				acc_status = mfde_pkg::STAT_Y2_OUT;
			end
		end
	end

	// Byte address and bit mask for the cursor position.
	always_comb begin
		row_flip  = ~cur_y_q;
		draw_addr = {row_flip[RW-2:0], row_flip[RW-1], cur_c_q};
		lo_cur    = (cur_c_q == ca_q) ? lo_q : '0;
		hi_cur    = (cur_c_q == cb_q) ? hi_q : '1;
		mask_cur  = (8'hFF >> lo_cur) & (8'hFF << (3'd7 - hi_cur));
		last_byte = (cur_c_q == cb_q) && (cur_y_q == yb_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mfde_pkg::S_CLEAR: begin
				if (&clr_cnt_q) state_d = mfde_pkg::S_IDLE;
			end
			mfde_pkg::S_IDLE: begin
				if (cmd_acc) begin
					if (cmd.func == mfde_pkg::FN_READ) state_d = mfde_pkg::S_READ;
					else if (pix_reject)               state_d = mfde_pkg::S_DONE;
					else                               state_d = mfde_pkg::S_DRAW;
				end
			end
			mfde_pkg::S_DRAW: begin
				if (last_byte) state_d = mfde_pkg::S_DRAIN;
			end
			mfde_pkg::S_DRAIN:  state_d = mfde_pkg::S_DONE;
			mfde_pkg::S_READ:   state_d = mfde_pkg::S_RDWAIT;
			mfde_pkg::S_RDWAIT: state_d = mfde_pkg::S_DONE;
			mfde_pkg::S_DONE: begin
				if (rsp_free) state_d = mfde_pkg::S_IDLE;
			end
			default: state_d = mfde_pkg::S_CLEAR;
		endcase
	end

	// Outputs of the sequencer: handshake and RAM ports.
	always_comb begin
		cmd_stall = (state_q != mfde_pkg::S_IDLE);
		ram_raddr = (state_q == mfde_pkg::S_READ) ? addr_q : draw_addr;
		if (state_q == mfde_pkg::S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = vld_s1;
			ram_waddr = addr_s1;
			if (inv_q)        ram_wdata = ram_rdata ^ mask_s1;
			else if (color_q) ram_wdata = ram_rdata | mask_s1;
			else              ram_wdata = ram_rdata & ~mask_s1;
		end
	end

	// State and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mfde_pkg::S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mfde_pkg::S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Operation registers and cursor walk.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			yb_q     <= yb;
			ca_q     <= xa[CW-1:XW];
			cb_q     <= xb[CW-1:XW];
			lo_q     <= xa[XW-1:0];
			hi_q     <= xb[XW-1:0];
			cur_y_q  <= ya;
			cur_c_q  <= xa[CW-1:XW];
			inv_q    <= (cmd.func == mfde_pkg::FN_INVERT);
			color_q  <= cmd.color;
			addr_q   <= cmd.addr;
			status_q <= (cmd.func == mfde_pkg::FN_READ) ? mfde_pkg::STAT_OK : acc_status;
			data_q   <= '0;
		end else if (state_q == mfde_pkg::S_DRAW) begin
			if (cur_c_q == cb_q) begin
				cur_c_q <= ca_q;
				cur_y_q <= cur_y_q + 1'b1;
			end else begin
				cur_c_q <= cur_c_q + 1'b1;
			end
		end else if (state_q == mfde_pkg::S_RDWAIT) begin
			data_q <= ram_rdata;
		end
	end

	// Modify stage: the byte read this cycle is written back next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == mfde_pkg::S_DRAW);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= draw_addr;
		mask_s1 <= mask_cur;
	end

	// Response output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == mfde_pkg::S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mfde_pkg::S_DONE && rsp_free) begin
			rsp_q.status    <= status_q;
			rsp_q.read_data <= data_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Frame store.
	mfde_ram #(
		.WIDTH (DW),
		.DEPTH (mfde_pkg::STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// Write-back only follows a draw cycle.
	a_wb_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == mfde_pkg::S_DRAW || state_q == mfde_pkg::S_DRAIN))
		else $error("write-back outside a draw");

	// No response appears while the store is being cleared.
	a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfde_pkg::S_CLEAR) |-> !rsp_valid)
		else $error("response during clearing pass");

	// A read reports status zero.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfde_pkg::S_RDWAIT) |-> (status_q == mfde_pkg::STAT_OK))
		else $error("read with non-zero status");

	// A finished draw leaves the sequencer through the drain cycle.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfde_pkg::S_DRAW && last_byte) |=> (state_q == mfde_pkg::S_DRAIN))
		else $error("draw did not drain");
`endif

endmodule

[rtl/core/mfde_ram.sv]
// ----------------------------------------------------------------------------
// mfde_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module mfde_ram #(
	parameter int WIDTH = mfde_pkg::BYTE_W,
	parameter int DEPTH = mfde_pkg::STORE_BYTES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[dv/mono_framebuffer_draw_engine_test.sv]
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_test
// Self-checking bench for the monochrome frame store draw engine. A shadow
// copy of the frame store predicts every response beat: pixel writes,
// clamped and sorted rectangle fills and inverts, and byte reads. The bench
// starts with directed corner cases and then runs a long random mix, with
// random idling on both channels, one long receiver hold-off and one full
// drain pause.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_test;

	import mfde_pkg::*;

	localparam int MAX_COL       = 127;
	localparam int MAX_ROW       = 63;
	localparam int RANDOM_CMDS   = 520;
	localparam int HOLD_AT_RSP   = 150;
	localparam int HOLD_CYCLES   = 2500;
	localparam int DRAIN_AT_CMD  = 350;
	localparam int TAIL_CYCLES   = 64;
	localparam int RUN_LIMIT     = 24_000_000;

	// Shadow frame store, expected response beats and the mismatch count.
	class draw_scoreboard;
		logic [BYTE_W-1:0] shadow_store [STORE_BYTES];
		rsp_t              expected_rsp [$];
		int                errors;

		function new();
			foreach (shadow_store[i]) shadow_store[i] = '0;
			errors = 0;
		endfunction

		// Row flip, then rows 32..63 of the flipped frame sit 16 bytes on.
		function int byte_index(int x, int y);
			int row;
			int col;
			row = MAX_ROW - y;
			col = x / 8;
			if (row > 31) begin
				col += 16;
				row -= 32;
			end
			return row * 32 + col;
		endfunction

		function void paint(int x, int y, func_t f, logic color);
			int          idx;
			logic [7:0]  mask;
			idx  = byte_index(x, y);
			mask = 8'h80 >> (x % 8);
			if (f == FN_INVERT)
				shadow_store[idx] ^= mask;
			else if (color)
				shadow_store[idx] |= mask;
			else
				shadow_store[idx] &= ~mask;
		endfunction

		// Clamp each corner, keep the first fault, sort, then walk the area.
		function status_t draw_rect(cmd_t c);
			int      xa;
			int      ya;
			int      xb;
			int      yb;
			int      swap;
			status_t st;
			st = STAT_OK;
			xa = int'(c.x1);
			ya = int'(c.y1);
			xb = int'(c.x2);
			yb = int'(c.y2);
			if (xa > MAX_COL) begin
				xa = MAX_COL;
				if (st == STAT_OK) st = STAT_X1_OUT;
			end
			if (ya > MAX_ROW) begin
				ya = MAX_ROW;
				if (st == STAT_OK) st = STAT_Y1_OUT;
			end
			if (xb > MAX_COL) begin
				xb = MAX_COL;
				if (st == STAT_OK) st = STAT_X2_OUT;
			end
			if (yb > MAX_ROW) begin
				yb = MAX_ROW;
				if (st == STAT_OK) st = STAT_Y2_OUT;
			end
			if (xa > xb) begin
				swap = xa;
				xa = xb;
				xb = swap;
			end
			if (ya > yb) begin
				swap = ya;
				ya = yb;
				yb = swap;
			end
			for (int y = ya; y <= yb; y++)
				for (int x = xa; x <= xb; x++)
					paint(x, y, c.func, c.color);
			return st;
		endfunction

		// An accepted command beat updates the shadow store and queues its response.
		function void note_command(cmd_t c);
			rsp_t r;
			r.status    = STAT_OK;
			r.read_data = '0;
			case (c.func)
				FN_PIXEL: begin
					if (c.x1 > MAX_COL)
						r.status = STAT_X1_OUT;
					else if (c.y1 > MAX_ROW)
						r.status = STAT_Y1_OUT;
					else
						paint(int'(c.x1), int'(c.y1), FN_PIXEL, c.color);
				end
				FN_FILL, FN_INVERT: begin
					r.status = draw_rect(c);
				end
				default: begin
					r.read_data = shadow_store[c.addr];
				end
			endcase
			expected_rsp.push_back(r);
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		// An accepted response beat is compared with the oldest expectation.
		task check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				report("response beat with no command outstanding");
			end else begin
				want = expected_rsp.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.read_data !== want.read_data)
					report($sformatf("read_data %02h, expected %02h",
						got.read_data, want.read_data));
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_stall;
	cmd_t  cmd       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	draw_scoreboard sb = new();
	int             sent_count = 0;
	int             last_x     = 0;
	int             last_y     = 0;

	mono_framebuffer_draw_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#RUN_LIMIT;
		$display("mono_framebuffer_draw_engine verification failed");
		$finish;
	end

	function automatic cmd_t make_cmd(func_t f, int x1, int y1, int x2, int y2,
		logic color, int addr);
		cmd_t c;
		c.func  = f;
		c.x1    = 8'(x1);
		c.y1    = 8'(y1);
		c.x2    = 8'(x2);
		c.y2    = 8'(y2);
		c.color = color;
		c.addr  = STORE_AW'(addr);
		return c;
	endfunction

	function automatic int rand_col();
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(MAX_COL + 1, 255);
		return $urandom_range(0, MAX_COL);
	endfunction

	function automatic int rand_row();
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(MAX_ROW + 1, 255);
		return $urandom_range(0, MAX_ROW);
	endfunction

	// Random command: unused fields stay random, rectangles are mostly small.
	function automatic cmd_t random_command();
		cmd_t c;
		c.func  = func_t'($urandom_range(0, 3));
		c.x1    = 8'($urandom_range(0, 255));
		c.y1    = 8'($urandom_range(0, 255));
		c.x2    = 8'($urandom_range(0, 255));
		c.y2    = 8'($urandom_range(0, 255));
		c.color = 1'($urandom_range(0, 1));
		c.addr  = STORE_AW'($urandom_range(0, STORE_BYTES - 1));
		case (c.func)
			FN_PIXEL: begin
				c.x1 = 8'(rand_col());
				c.y1 = 8'(rand_row());
			end
			FN_FILL, FN_INVERT: begin
				if ($urandom_range(0, 24) != 0) begin
					c.x1 = 8'(rand_col());
					c.y1 = 8'(rand_row());
					c.x2 = 8'(c.x1 + $urandom_range(0, 16) - 8);
					c.y2 = 8'(c.y1 + $urandom_range(0, 12) - 6);
				end
			end
			default: begin
				// Half the reads look at a byte that was recently drawn.
				if ($urandom_range(0, 1) == 1)
					c.addr = STORE_AW'(sb.byte_index(last_x, last_y));
			end
		endcase
		if (c.func != FN_READ) begin
			last_x = (c.x1 > MAX_COL) ? MAX_COL : int'(c.x1);
			last_y = (c.y1 > MAX_ROW) ? MAX_ROW : int'(c.y1);
		end
		return c;
	endfunction

	// Idle gap before a beat, with stretches of back-to-back traffic.
	function automatic int next_gap(int n);
		if ((n / 48) % 5 == 2)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	// Offer one command beat and wait for it to be taken.
	task automatic send_command(cmd_t c);
		int gap;
		gap = next_gap(sent_count);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		sb.note_command(c);
		sent_count++;
	endtask

	// Stop offering until every outstanding response has come back.
	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Response side: random stalls, one long hold-off to back the block up.
	initial begin : response_side
		int gap;
		int taken;
		taken = 0;
		forever begin
			if (taken == HOLD_AT_RSP)
				gap = HOLD_CYCLES;
			else if ((taken / 40) % 4 == 1)
				gap = 0;
			else
				gap = $urandom_range(0, 12);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			sb.check_response(rsp);
			taken++;
		end
	end

	// Reset, directed commands, random commands, final drain and verdict.
	initial begin : command_side
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads of the cleared store at both ends.
		send_command(make_cmd(FN_READ, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 0));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
		// Pixels at the four corners and rejected coordinates.
		send_command(make_cmd(FN_PIXEL, 0, 0, 8'hff, 8'hff, 1'b1, 10'h3ff));
		send_command(make_cmd(FN_PIXEL, MAX_COL, MAX_ROW, 0, 0, 1'b1, 0));
		send_command(make_cmd(FN_PIXEL, MAX_COL, 0, 0, 0, 1'b1, 0));
		send_command(make_cmd(FN_PIXEL, 0, MAX_ROW, 0, 0, 1'b1, 0));
		send_command(make_cmd(FN_PIXEL, MAX_COL + 1, 0, 0, 0, 1'b1, 0));
		send_command(make_cmd(FN_PIXEL, 0, MAX_ROW + 1, 0, 0, 1'b1, 0));
		send_command(make_cmd(FN_PIXEL, 255, 255, 0, 0, 1'b1, 0));
		send_command(make_cmd(FN_PIXEL, 0, 0, 0, 0, 1'b0, 0));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, sb.byte_index(0, 0)));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, sb.byte_index(MAX_COL, 0)));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, sb.byte_index(0, MAX_ROW)));
		// Full screen fill, then one fault of each corner in turn.
		send_command(make_cmd(FN_FILL, 0, 0, MAX_COL, MAX_ROW, 1'b1, 0));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, 512));
		send_command(make_cmd(FN_FILL, 200, 70, 10, 5, 1'b0, 0));
		send_command(make_cmd(FN_INVERT, 3, 100, 130, 70, 1'b0, 0));
		send_command(make_cmd(FN_FILL, 20, 30, 130, 10, 1'b0, 0));
		send_command(make_cmd(FN_INVERT, 40, 2, 45, 200, 1'b1, 0));
		// Swapped corners and a full invert with the first corner clamped.
		send_command(make_cmd(FN_FILL, 100, 50, 10, 5, 1'b1, 0));
		send_command(make_cmd(FN_INVERT, 255, 255, 0, 0, 1'b1, 0));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, 16));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, 1008));
		send_command(make_cmd(FN_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));

		// Random mix, with one pause until the block has fully drained.
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n == DRAIN_AT_CMD)
				wait_for_drain();
			send_command(random_command());
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("mono_framebuffer_draw_engine verification clean");
		else
			$display("mono_framebuffer_draw_engine verification failed");
		$finish;
	end

endmodule
